// ----- hdl/nhl1_pkg.sv -----
package nhl1_pkg;

   localparam int PIXEL_BITS_DEFAULT = 8;
   localparam int FRAC_BITS_DEFAULT  = 8;

   function automatic int byte_round(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

// ----- hdl/nohalo_level1_resampler_unit.sv -----
// Channel | Direction | Contents of tdata
// req_    | in        | row_top, row_upper, row_lower, row_bottom, frac_x, frac_y
// rsp_    | out       | result_pixel
//
// Every beat passes five register stages, the last of which is the output register, and
// a new beat can enter on every cycle in which the result side does not stall. The five
// stages are the input mirror, the slope limiters, the slope sums, the four weight
// multipliers, and the final add, round and clamp. Reset clears only the valid bits. A
// stall on the result side freezes the whole pipeline, so nothing is lost or repeated.
module nohalo_level1_resampler_unit
   import nhl1_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // row_top, row_upper, row_lower, row_bottom, frac_x, frac_y from the lowest bit up
   input  logic [byte_round(12*PIXEL_BITS+2*FRAC_BITS)-1:0] req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // result_pixel
   output logic [byte_round(PIXEL_BITS)-1:0]          rsp_tdata
);

   localparam int PW = PIXEL_BITS;
   localparam int FW = FRAC_BITS;
   localparam int DW = PW + 1;
   localparam int RW = PW + 6;
   localparam int SW = 2 * FW + PW + 7;
   localparam int QW = SW - 2 - 2 * FW;
   localparam int OUT_BITS = byte_round(PIXEL_BITS);
   localparam logic [FW-1:0] HALF = {1'b1, {(FW-1){1'b0}}};

   function automatic logic signed [DW-1:0] minmod(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic [DW-1:0] mag_a;
      logic [DW-1:0] mag_b;
      logic signed [DW-1:0] res;
      mag_a = a[DW-1] ? $unsigned(-a) : $unsigned(a);
      mag_b = b[DW-1] ? $unsigned(-b) : $unsigned(b);
      if (a == '0 || b == '0 || a[DW-1] != b[DW-1]) begin
         res = '0;
      end else if (mag_a <= mag_b) begin
         res = a;
      end else begin
         res = b;
      end
      return res;
   endfunction

   function automatic logic signed [DW-1:0] diff(input logic [PW-1:0] a,
                                                  input logic [PW-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign en         = !v5_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v5_ff;

   // Stage 1: unpack, mirror toward the nearest central pixel, weights.
   logic [2*PW-1:0] row_top, row_bottom;
   logic [4*PW-1:0] row_upper, row_lower;
   logic [FW-1:0]   frac_x, frac_y;
   logic [PW-1:0]   g [4][4];
   logic [PW-1:0]   s_in [4][4];
   logic [PW-1:0]   s_ff [4][4];
   logic [FW-1:0]   w_in, x_in, z_in, y_in;
   logic [FW-1:0]   w_ff, x_ff, z_ff, y_ff;

   assign row_top    = req_tdata[2*PW-1:0];
   assign row_upper  = req_tdata[6*PW-1:2*PW];
   assign row_lower  = req_tdata[10*PW-1:6*PW];
   assign row_bottom = req_tdata[12*PW-1:10*PW];
   assign frac_x     = req_tdata[12*PW+FW-1:12*PW];
   assign frac_y     = req_tdata[12*PW+2*FW-1:12*PW+FW];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            g[j][i] = '0;
         end
      end
      for (int i = 0; i < 2; i++) begin
         g[0][i+1] = row_top[i*PW +: PW];
         g[3][i+1] = row_bottom[i*PW +: PW];
      end
      for (int i = 0; i < 4; i++) begin
         g[1][i] = row_upper[i*PW +: PW];
         g[2][i] = row_lower[i*PW +: PW];
      end
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            s_in[j][i] = g[2'(j) ^ {2{frac_y[FW-1]}}][2'(i) ^ {2{frac_x[FW-1]}}];
         end
      end
      w_in = frac_x[FW-1] ? frac_x - HALF : HALF - frac_x;
      z_in = frac_y[FW-1] ? frac_y - HALF : HALF - frac_y;
      x_in = HALF - w_in;
      y_in = HALF - z_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
         w_ff <= w_in;
         x_ff <= x_in;
         z_ff <= z_in;
         y_ff <= y_in;
      end
   end

   // Stage 2: limited slopes and weight products.
   logic signed [DW-1:0] h0a, h1a, h2a, h0b, h1b, h2b;
   logic signed [DW-1:0] v0a, v1a, v2a, v0b, v1b, v2b;
   logic signed [DW-1:0] mha0_ff, mha2_ff, mhb0_ff, mhb2_ff;
   logic signed [DW-1:0] mva0_ff, mva2_ff, mvb0_ff, mvb2_ff;
   logic signed [DW:0]   cross_ff;
   logic [PW:0]          sum_r1_ff, sum_r2_ff;
   logic [PW-1:0]        p2_ff;
   logic [2*FW-1:0]      wz_ff, xz_ff, wy_ff, xy_ff;

   assign h0a = diff(s_ff[1][1], s_ff[1][0]);
   assign h1a = diff(s_ff[1][2], s_ff[1][1]);
   assign h2a = diff(s_ff[1][3], s_ff[1][2]);
   assign h0b = diff(s_ff[2][1], s_ff[2][0]);
   assign h1b = diff(s_ff[2][2], s_ff[2][1]);
   assign h2b = diff(s_ff[2][3], s_ff[2][2]);
   assign v0a = diff(s_ff[1][1], s_ff[0][1]);
   assign v1a = diff(s_ff[2][1], s_ff[1][1]);
   assign v2a = diff(s_ff[3][1], s_ff[2][1]);
   assign v0b = diff(s_ff[1][2], s_ff[0][2]);
   assign v1b = diff(s_ff[2][2], s_ff[1][2]);
   assign v2b = diff(s_ff[3][2], s_ff[2][2]);

   always_ff @(posedge clock) begin
      if (en) begin
         mha0_ff   <= minmod(h1a, h0a);
         mha2_ff   <= minmod(h1a, h2a);
         mhb0_ff   <= minmod(h1b, h0b);
         mhb2_ff   <= minmod(h1b, h2b);
         mva0_ff   <= minmod(v1a, v0a);
         mva2_ff   <= minmod(v1a, v2a);
         mvb0_ff   <= minmod(v1b, v0b);
         mvb2_ff   <= minmod(v1b, v2b);
         cross_ff  <= (DW+1)'(v1b) + (DW+1)'(h1a);
         sum_r1_ff <= {1'b0, s_ff[1][1]} + {1'b0, s_ff[1][2]};
         sum_r2_ff <= {1'b0, s_ff[1][1]} + {1'b0, s_ff[2][1]};
         p2_ff     <= s_ff[1][1];
         wz_ff     <= {{FW{1'b0}}, w_ff} * {{FW{1'b0}}, z_ff};
         xz_ff     <= {{FW{1'b0}}, x_ff} * {{FW{1'b0}}, z_ff};
         wy_ff     <= {{FW{1'b0}}, w_ff} * {{FW{1'b0}}, y_ff};
         xy_ff     <= {{FW{1'b0}}, x_ff} * {{FW{1'b0}}, y_ff};
      end
   end

   // Stage 3: the three double-density values.
   logic signed [RW-1:0] r1_in, r2_in, r3_in;
   logic signed [RW-1:0] r1_ff, r2_ff, r3_ff;
   logic [PW-1:0]        p3_ff;
   logic [2*FW-1:0]      wz3_ff, xz3_ff, wy3_ff, xy3_ff;

   always_comb begin
      r1_in = RW'(mha0_ff) - RW'(mha2_ff) + $signed(RW'({sum_r1_ff, 1'b0}));
      r2_in = RW'(mva0_ff) - RW'(mva2_ff) + $signed(RW'({sum_r2_ff, 1'b0}));
      r3_in = r1_in + r2_in + (RW'(cross_ff) <<< 1)
            + RW'(mhb0_ff) - RW'(mhb2_ff) + RW'(mvb0_ff) - RW'(mvb2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         r3_ff  <= r3_in;
         p3_ff  <= p2_ff;
         wz3_ff <= wz_ff;
         xz3_ff <= xz_ff;
         wy3_ff <= wy_ff;
         xy3_ff <= xy_ff;
      end
   end

   // Stage 4: weighted terms.
   logic signed [SW-1:0] t0_ff, t1_ff, t2_ff, t3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff <= $signed((SW'(wz3_ff) * SW'(p3_ff)) << 3);
         t1_ff <= (SW'($signed({1'b0, xz3_ff})) * SW'(r1_ff)) <<< 1;
         t2_ff <= (SW'($signed({1'b0, wy3_ff})) * SW'(r2_ff)) <<< 1;
         t3_ff <= SW'($signed({1'b0, xy3_ff})) * SW'(r3_ff);
      end
   end

   // Stage 5: sum, round half up, clamp.
   logic signed [SW-1:0] num;
   logic [QW-1:0]        quot;
   logic [PW-1:0]        pix_in, pix_ff;

   always_comb begin
      num  = t0_ff + t1_ff + t2_ff + t3_ff + (SW'(1) <<< (2 * FW));
      quot = num[SW-2:2*FW+1];
      if (num[SW-1]) begin
         pix_in = '0;
      end else if (|quot[QW-1:PW]) begin
         pix_in = '1;
      end else begin
         pix_in = quot[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp_tdata = OUT_BITS'(pix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

endmodule
